// File: design/windowed_nearest_entry_search_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed nearest-entry search unit
// Concurrent checks sampled on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_NEAREST_ENTRY_SEARCH_UNIT_MACROS_SVH
`define WINDOWED_NEAREST_ENTRY_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define WNES_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wnes: same-cycle property violated");

// Next-cycle implication.
`define WNES_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wnes: next-cycle property violated");

`endif

// File: design/wnes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnes_pkg
// Field widths, codes and the table entry record of the search unit.
// ----------------------------------------------------------------------------
package wnes_pkg;

    localparam int GRID_W     = 16;
    localparam int LAT_W      = 28;
    localparam int LON_W      = 29;
    localparam int COUNT_W    = 13;
    localparam int INDEX_W    = 12;
    localparam int DLAT_W     = LAT_W + 1;
    localparam int DLON_W     = LON_W + 1;
    localparam int DIST_W     = 2 * DLON_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef struct packed {
        logic signed [GRID_W-1:0] grid_x;
        logic signed [GRID_W-1:0] grid_y;
        logic signed [LAT_W-1:0]  latitude;
        logic signed [LON_W-1:0]  longitude;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: design/windowed_nearest_entry_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_nearest_entry_search_unit
// Loads a table of reference points and finds, for a query cell and position,
// the nearest entry inside the three by three grid window around the cell.
// ----------------------------------------------------------------------------
//
//  channel  handshake              word
//  -------  ---------------------  ----------------------------------------
//  in       in_valid / in_stall    operation, entry_index, grid_x, grid_y,
//                                  latitude, longitude
//  out      out_valid / out_stall  found, best_index
//  cfg      APB psel/penable/...   entry_count at byte address 0
//
//  A load word writes the table at its accept edge.
//  A query passes S_DIFF for each entry outside the window and S_DIFF,
//  S_MUL_LAT, S_MUL_LON and S_CMP for each inside, then S_DONE; this is set
//  by the single table read port (one entry per cycle) and the one shared
//  squaring multiplier, used twice for each entry inside.
//  in_stall is high for the whole of a query; a finished result waits in the
//  output register, so a new word is taken while the old result is held.
//  Reset clears control state and entry_count; the table has no clearing pass.
// ----------------------------------------------------------------------------
module windowed_nearest_entry_search_unit #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input words
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   operation,
    input  logic [wnes_pkg::INDEX_W-1:0]           entry_index,
    input  logic signed [wnes_pkg::GRID_W-1:0]     grid_x,
    input  logic signed [wnes_pkg::GRID_W-1:0]     grid_y,
    input  logic signed [wnes_pkg::LAT_W-1:0]      latitude,
    input  logic signed [wnes_pkg::LON_W-1:0]      longitude,
    // result words
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   found,
    output logic [wnes_pkg::INDEX_W-1:0]           best_index,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [wnes_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [wnes_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [wnes_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    import wnes_pkg::*;

    `include "windowed_nearest_entry_search_unit_macros.svh"

    localparam int ADDR_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int IDX_EXT_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL_LAT,
        S_MUL_LON,
        S_CMP,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_acc_reg, found_acc_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [INDEX_W-1:0]  best_index_reg, best_index_next;
    logic [COUNT_W-1:0]  entry_count_reg, entry_count_next;

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic signed [GRID_W-1:0] q_gx_reg, q_gy_reg;
    logic signed [LAT_W-1:0]  q_lat_reg;
    logic signed [LON_W-1:0]  q_lon_reg;
    logic [DLAT_W-1:0]        dlat_reg;
    logic [DLON_W-1:0]        dlon_reg;
    logic [DIST_W-1:0]        sq_lat_reg, sq_lon_reg, best_dist_reg;

    logic                     in_accept, is_query, is_load;
    logic                     cfg_write;

    // table ports
    logic                     wr_en, rd_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    entry_t                   wr_entry, rd_entry;
    logic [ENTRY_W-1:0]       rd_word;
    logic [IDX_EXT_W-1:0]     wr_index_ext, best_idx_ext;

    // scan limit, saturated to the table depth
    logic [LIM_W-1:0]         count_ext, limit_wide;
    logic [CNT_W-1:0]         limit, idx_plus;
    logic                     last_entry;

    // per-entry arithmetic
    logic signed [GRID_W:0]   dgx, dgy;
    logic                     in_window;
    logic signed [DLAT_W-1:0] dlat_s;
    logic signed [DLON_W-1:0] dlon_s;
    logic [DLAT_W-1:0]        dlat_abs;
    logic [DLON_W-1:0]        dlon_abs;
    logic [DLON_W-1:0]        mul_op;
    logic [DIST_W-1:0]        product, dist_sum;
    logic                     take_entry;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign is_query  = in_accept && (operation == OP_QUERY);
    assign is_load   = in_accept && (operation == OP_LOAD);

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign best_index = best_index_reg;

    // APB: always ready, one register at word 0
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata    = (paddr[2] == REG_ENTRY_COUNT) ?
                       APB_DATA_W'(entry_count_reg) : '0;

    assign count_ext  = LIM_W'(entry_count_reg);
    assign limit_wide = (count_ext > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : count_ext;
    assign limit      = limit_wide[CNT_W-1:0];
    assign idx_plus   = idx_reg + CNT_W'(1);
    assign last_entry = (idx_plus == limit);

    // ------------------------------------------------------------------
    // table write: loads beyond the table depth are dropped
    // ------------------------------------------------------------------
    assign wr_index_ext = IDX_EXT_W'(entry_index);
    assign wr_addr      = wr_index_ext[ADDR_W-1:0];
    assign wr_en        = is_load && (32'(entry_index) < 32'(MAX_ENTRIES));
    assign wr_entry     = '{grid_x: grid_x, grid_y: grid_y,
                            latitude: latitude, longitude: longitude};

    wnes_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    // ------------------------------------------------------------------
    // window test and absolute differences on the entry just read
    // ------------------------------------------------------------------
    assign dgx = {rd_entry.grid_x[GRID_W-1], rd_entry.grid_x} - {q_gx_reg[GRID_W-1], q_gx_reg};
    assign dgy = {rd_entry.grid_y[GRID_W-1], rd_entry.grid_y} - {q_gy_reg[GRID_W-1], q_gy_reg};
    assign in_window = (dgx == '0 || dgx == (GRID_W+1)'(1) || dgx == '1) &&
                       (dgy == '0 || dgy == (GRID_W+1)'(1) || dgy == '1);

    assign dlat_s   = {rd_entry.latitude[LAT_W-1], rd_entry.latitude} -
                      {q_lat_reg[LAT_W-1], q_lat_reg};
    assign dlon_s   = {rd_entry.longitude[LON_W-1], rd_entry.longitude} -
                      {q_lon_reg[LON_W-1], q_lon_reg};
    assign dlat_abs = dlat_s[DLAT_W-1] ? DLAT_W'(-dlat_s) : DLAT_W'(dlat_s);
    assign dlon_abs = dlon_s[DLON_W-1] ? DLON_W'(-dlon_s) : DLON_W'(dlon_s);

    // one shared squaring unit: latitude term first, then longitude term
    assign mul_op  = (state_reg == S_MUL_LAT) ? DLON_W'(dlat_reg) : dlon_reg;
    assign product = mul_op * mul_op;

    // both squares are below 2^59, so the sum cannot carry out
    assign dist_sum   = sq_lat_reg + sq_lon_reg;
    assign take_entry = !found_acc_reg || (dist_sum < best_dist_reg);

    assign best_idx_ext = IDX_EXT_W'(best_idx_reg);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        found_acc_next   = found_acc_reg;
        best_idx_next    = best_idx_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        best_index_next  = best_index_reg;
        entry_count_next = cfg_write ? pwdata[COUNT_W-1:0] : entry_count_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_plus[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (is_query)
                begin
                    idx_next       = '0;
                    found_acc_next = 1'b0;
                    best_idx_next  = '0;
                    if (limit == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // fetch entry 0 for the first compare
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                if (in_window)
                begin
                    state_next = S_MUL_LAT;
                end
                else if (last_entry)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // skip this entry and fetch the next one
                    idx_next = idx_plus;
                    rd_en    = 1'b1;
                end
            end
            S_MUL_LAT:
            begin
                state_next = S_MUL_LON;
            end
            S_MUL_LON:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (take_entry)
                begin
                    found_acc_next = 1'b1;
                    best_idx_next  = idx_reg[ADDR_W-1:0];
                end
                if (last_entry)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_plus;
                    rd_en      = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = found_acc_reg;
                    best_index_next = found_acc_reg ? best_idx_ext[INDEX_W-1:0] : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            found_acc_reg   <= 1'b0;
            best_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            best_index_reg  <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            found_acc_reg   <= found_acc_next;
            best_idx_reg    <= best_idx_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            best_index_reg  <= best_index_next;
            entry_count_reg <= entry_count_next;
        end
    end

    // datapath: capture the query, the differences, the squares and the best
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            q_gx_reg  <= grid_x;
            q_gy_reg  <= grid_y;
            q_lat_reg <= latitude;
            q_lon_reg <= longitude;
        end
        if (state_reg == S_DIFF)
        begin
            dlat_reg <= dlat_abs;
            dlon_reg <= dlon_abs;
        end
        if (state_reg == S_MUL_LAT)
        begin
            sq_lat_reg <= product;
        end
        if (state_reg == S_MUL_LON)
        begin
            sq_lon_reg <= product;
        end
        if (state_reg == S_CMP && take_entry)
        begin
            best_dist_reg <= dist_sum;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `WNES_ASSERT_IMP(a_write_only_idle, wr_en, state_reg == S_IDLE)
    `WNES_ASSERT_IMP(a_scan_in_range, state_reg == S_DIFF, idx_reg < limit)
    `WNES_ASSERT_IMP(a_miss_index_zero, out_valid_reg && !found_reg, best_index_reg == '0)
    `WNES_ASSERT_NXT(a_result_from_done, !out_valid_reg && state_reg != S_DONE, !out_valid_reg)

endmodule

// File: design/wnes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnes_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wnes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
